// ===== rtl/k_jump_min_cost_dp_assert.svh =====
// Assertion macros for the k-jump cost block.
// Each macro takes a label, clock, reset, a precondition and a consequence.
`ifndef K_JUMP_MIN_COST_DP_ASSERT_SVH
`define K_JUMP_MIN_COST_DP_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define KJMP_ASSERT_NOW(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("kjmp: same-cycle check failed");
`define KJMP_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("kjmp: next-cycle check failed");
`else
`define KJMP_ASSERT_NOW(lbl, clk, rst, pre, post)
`define KJMP_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

// ===== rtl/kjmp_pkg.sv =====
`timescale 1ns / 1ps
package kjmp_pkg;

   localparam int HEIGHT_BITS = 16;
   localparam int COST_BITS   = 32;
   localparam int CFG_BITS    = 5;

   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic                   last_item;
   } req_type;

   typedef struct packed {
      logic [COST_BITS-1:0] min_cost;
      logic                 is_last;
   } rsp_type;

   // one window slot
   typedef struct packed {
      logic [HEIGHT_BITS-1:0] height;
      logic [COST_BITS-1:0]   cost;
   } entry_type;

   typedef struct packed {
      logic start;      // new item: load initial best
      logic init_zero;  // no history: best starts (and stays) at zero
      logic acc;        // window entry on the read port is a candidate
   } unit_ctrl_type;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

endpackage

// ===== rtl/kjmp_window.sv =====
`timescale 1ns / 1ps
module kjmp_window #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [AW-1:0]       wr_addr,
   input  kjmp_pkg::entry_type wr_data,
   input  logic                rd_en,
   input  logic [AW-1:0]       rd_addr,
   output kjmp_pkg::entry_type rd_data
);

   kjmp_pkg::entry_type mem_ff [DEPTH];
   kjmp_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/kjmp_unit.sv =====
`timescale 1ns / 1ps
module kjmp_unit (
   input  logic                                clock,
   input  kjmp_pkg::unit_ctrl_type             ctrl,
   input  logic [kjmp_pkg::HEIGHT_BITS-1:0]    height,
   input  kjmp_pkg::entry_type                 entry,
   output logic [kjmp_pkg::COST_BITS-1:0]      best
);

   logic [kjmp_pkg::COST_BITS-1:0]   best_ff;
   logic [kjmp_pkg::COST_BITS-1:0]   best_in;
   logic [kjmp_pkg::HEIGHT_BITS-1:0] diff;
   logic [kjmp_pkg::COST_BITS:0]     sum;
   logic [kjmp_pkg::COST_BITS-1:0]   cand;

   always_comb begin
      diff = (height >= entry.height) ? (height - entry.height)
                                      : (entry.height - height);
      sum  = {1'b0, entry.cost} + (kjmp_pkg::COST_BITS+1)'(diff);
      // saturate on carry out
      cand = sum[kjmp_pkg::COST_BITS] ? '1 : sum[kjmp_pkg::COST_BITS-1:0];
      best_in = best_ff;
      if (ctrl.start) begin
         best_in = ctrl.init_zero ? '0 : '1;
      end else if (ctrl.acc && (cand < best_ff)) begin
         best_in = cand;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
   end

   assign best = best_ff;

endmodule

// ===== rtl/k_jump_min_cost_dp.sv =====
`timescale 1ns / 1ps
// An accepted item scans span = min(max_jump, history) window entries in SCAN, then passes
// DRAIN and FINISH before its result is registered; with no history it skips to FINISH.
// One window entry is read per cycle from the window RAM read port into one
// abs-diff / saturating-add / min unit; a new item is accepted only after the last one leaves
// FINISH, which waits while the previous result is held waiting on rsp_ready.
// Reset (synchronous, active high) empties the window and sets max_jump to 1.
module k_jump_min_cost_dp #(
   parameter int MAX_JUMP_LIMIT = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  kjmp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output kjmp_pkg::rsp_type               rsp_data,
   input  logic                            csr_wr_en,
   input  logic [kjmp_pkg::CFG_BITS-1:0]   csr_wr_data
);

   `include "k_jump_min_cost_dp_assert.svh"

   localparam int AW = (MAX_JUMP_LIMIT > 1) ? $clog2(MAX_JUMP_LIMIT) : 1;
   localparam int SW = $clog2(MAX_JUMP_LIMIT + 1);
   localparam int LW = (SW > kjmp_pkg::CFG_BITS) ? SW : kjmp_pkg::CFG_BITS;

   kjmp_pkg::state_type state_ff, state_in;

   logic [kjmp_pkg::CFG_BITS-1:0] max_jump_ff;
   logic [SW-1:0]                 seen_ff, seen_in;
   logic [AW-1:0]                 head_ff, head_in;
   logic [AW-1:0]                 rd_ptr_ff, rd_ptr_in;
   logic [SW-1:0]                 cnt_ff, cnt_in;
   logic [SW-1:0]                 span_ff, span_in;
   logic                          rd_valid_ff;
   kjmp_pkg::req_type             hold_ff;
   logic                          rsp_valid_ff, rsp_valid_in;
   kjmp_pkg::rsp_type             rsp_data_ff;

   logic [LW-1:0]                 k_w;
   logic [SW-1:0]                 span_now;
   logic                          accept;
   logic                          out_free;
   logic                          finish_fire;
   logic [AW-1:0]                 head_prev;

   kjmp_pkg::unit_ctrl_type       uctrl;
   kjmp_pkg::entry_type           wr_entry;
   kjmp_pkg::entry_type           rd_entry;
   logic [kjmp_pkg::COST_BITS-1:0] best;

   function automatic logic [AW-1:0] ptr_prev(input logic [AW-1:0] p);
      ptr_prev = (p == '0) ? AW'(MAX_JUMP_LIMIT - 1) : (p - AW'(1));
   endfunction

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      ptr_next = (p == AW'(MAX_JUMP_LIMIT - 1)) ? '0 : (p + AW'(1));
   endfunction

   // span = min(clamp(max_jump, 1, limit), seen)
   always_comb begin
      k_w = LW'(max_jump_ff);
      if (k_w == '0) begin
         k_w = LW'(1);
      end
      if (k_w > LW'(MAX_JUMP_LIMIT)) begin
         k_w = LW'(MAX_JUMP_LIMIT);
      end
      if (k_w > LW'(seen_ff)) begin
         k_w = LW'(seen_ff);
      end
      span_now = k_w[SW-1:0];
   end

   assign req_ready   = (state_ff == kjmp_pkg::ST_IDLE);
   assign accept      = req_valid && req_ready;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign finish_fire = (state_ff == kjmp_pkg::ST_FINISH) && out_free;
   assign head_prev   = ptr_prev(head_ff);

   always_comb begin
      state_in  = state_ff;
      seen_in   = seen_ff;
      head_in   = head_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      span_in   = span_ff;
      case (state_ff)
         kjmp_pkg::ST_IDLE: begin
            if (accept) begin
               span_in   = span_now;
               cnt_in    = '0;
               rd_ptr_in = head_prev;
               state_in  = (span_now == '0) ? kjmp_pkg::ST_FINISH : kjmp_pkg::ST_SCAN;
            end
         end
         kjmp_pkg::ST_SCAN: begin
            rd_ptr_in = ptr_prev(rd_ptr_ff);
            cnt_in    = cnt_ff + SW'(1);
            if (cnt_ff == span_ff - SW'(1)) begin
               state_in = kjmp_pkg::ST_DRAIN;
            end
         end
         kjmp_pkg::ST_DRAIN: begin
            state_in = kjmp_pkg::ST_FINISH;
         end
         kjmp_pkg::ST_FINISH: begin
            if (out_free) begin
               state_in = kjmp_pkg::ST_IDLE;
               if (hold_ff.last_item) begin
                  seen_in = '0;
               end else begin
                  head_in = ptr_next(head_ff);
                  if (seen_ff < SW'(MAX_JUMP_LIMIT)) begin
                     seen_in = seen_ff + SW'(1);
                  end
               end
            end
         end
         default: begin
            state_in = kjmp_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kjmp_pkg::ST_IDLE;
         max_jump_ff  <= kjmp_pkg::CFG_BITS'(1);
         seen_ff      <= '0;
         head_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         head_ff      <= head_in;
         rd_valid_ff  <= (state_ff == kjmp_pkg::ST_SCAN);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            max_jump_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      cnt_ff    <= cnt_in;
      span_ff   <= span_in;
      if (accept) begin
         hold_ff <= req_data;
      end
      if (finish_fire) begin
         rsp_data_ff.min_cost <= best;
         rsp_data_ff.is_last  <= hold_ff.last_item;
      end
   end

   assign uctrl.start     = accept;
   assign uctrl.init_zero = (span_now == '0);
   assign uctrl.acc       = rd_valid_ff;

   kjmp_unit u_unit (
      .clock  (clock),
      .ctrl   (uctrl),
      .height (hold_ff.height),
      .entry  (rd_entry),
      .best   (best)
   );

   assign wr_entry.height = hold_ff.height;
   assign wr_entry.cost   = best;

   kjmp_window #(
      .DEPTH (MAX_JUMP_LIMIT),
      .AW    (AW)
   ) u_window (
      .clock   (clock),
      .wr_en   (finish_fire && !hold_ff.last_item),
      .wr_addr (head_ff),
      .wr_data (wr_entry),
      .rd_en   (state_ff == kjmp_pkg::ST_SCAN),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_entry)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `KJMP_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_ready)
   `KJMP_ASSERT_NEXT(a_last_clears_window, clock, reset, finish_fire && hold_ff.last_item, seen_ff == '0)
   `KJMP_ASSERT_NOW(a_scan_in_span, clock, reset, state_ff == kjmp_pkg::ST_SCAN, (cnt_ff < span_ff) && (span_ff <= seen_ff))

endmodule
